[rtl/core/rvx_pkg.sv]
// rvx_pkg: shared types, opcode codes and size defaults for the rv64 subset executor
// used by every module under rtl/core; depends on nothing
package rvx_pkg;

   // default store depths (words); both are powers of two
   localparam int DEF_DATA_WORDS  = 32768;
   localparam int DEF_INSTR_WORDS = 32768;

   localparam int XLEN      = 64;
   localparam int IWORD_W   = 32;
   localparam int REG_IDX_W = 5;
   localparam int RF_DEPTH  = 32;
   localparam int IMM_W     = 21;
   localparam int FETCH_W   = 17;
   localparam int HALT_W    = 2;

   // decoupling queue between decode and execute
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // configuration registers
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_REG = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_VAL = 1'd1;
   localparam logic [REG_IDX_W-1:0] STOP_REG_RST = 5'd9;
   localparam logic [XLEN-1:0]      STOP_VAL_RST = 64'd10;

   // major opcodes
   localparam logic [6:0] OPCODE_ADD  = 7'h33;
   localparam logic [6:0] OPCODE_ADDI = 7'h13;
   localparam logic [6:0] OPCODE_JAL  = 7'h6f;
   localparam logic [6:0] OPCODE_JALR = 7'h67;
   localparam logic [6:0] OPCODE_BEQ  = 7'h63;
   localparam logic [6:0] OPCODE_LD   = 7'h03;
   localparam logic [6:0] OPCODE_SD   = 7'h23;

   // halt status codes
   localparam logic [HALT_W-1:0] HALT_RUN  = 2'd0;
   localparam logic [HALT_W-1:0] HALT_ZERO = 2'd1;
   localparam logic [HALT_W-1:0] HALT_STOP = 2'd2;

   typedef enum logic [2:0] {
      OPC_NONE,
      OPC_ADD,
      OPC_ADDI,
      OPC_JAL,
      OPC_JALR,
      OPC_BEQ,
      OPC_LD,
      OPC_SD
   } op_type;

   typedef struct packed {
      logic                        is_zero;
      op_type                      op;
      logic [REG_IDX_W-1:0]        rd;
      logic [REG_IDX_W-1:0]        rs1;
      logic [REG_IDX_W-1:0]        rs2;
      logic signed [IMM_W-1:0]     imm;
   } dec_type;

endpackage

[rtl/core/rv64_subset_instruction_executor.sv]
// rv64_subset_instruction_executor: top level, decode front, word queue and execute back
// depends on rvx_pkg, rvx_front, rvx_queue, rvx_back
//
// usage:
//   req_* carries one 32-bit instruction word per handshake, the word at the current pc.
//   rsp_* returns one result word per instruction: next fetch byte address, register
//   write (enable, index, value) and the sticky halt status.
//   csr_* writes stop_register (index 0) and stop_value (index 1); the user must
//   write them only while the block is idle; the block itself does not enforce it.
// sequencing:
//   a word is decoded on entry and parked in a two-deep queue. the execute sequencer
//   steps through a register file read state and an execute state; ld adds a load
//   state for the registered data store read. the result register and rsp_valid load
//   as execute completes. the sequencer takes the next word from the queue only after
//   the previous one has committed; the queue keeps accepting words until it is full.
// reset: pc, halt status, register file valid bits and queue are cleared; stop_register
//   returns to 9 and stop_value to 10. data store contents are undefined until written.
// stall: the result register holds while rsp_ready is low; execute waits on it and the
//   queue keeps taking words until full, then req_ready drops.
// instruction and data depths must be powers of two.
module rv64_subset_instruction_executor
   import rvx_pkg::*;
#(
   parameter int DATA_WORDS  = DEF_DATA_WORDS,
   parameter int INSTR_WORDS = DEF_INSTR_WORDS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [XLEN-1:0]        csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [IWORD_W-1:0]     req_instruction_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FETCH_W-1:0]     rsp_next_fetch_address,
   output logic                   rsp_write_enable,
   output logic [REG_IDX_W-1:0]   rsp_write_index,
   output logic signed [XLEN-1:0] rsp_write_value,
   output logic [HALT_W-1:0]      rsp_halt_status
);

   dec_type dec;
   dec_type q_data;
   logic    q_valid;
   logic    q_pop;

   rvx_front u_front (
      .instruction_word (req_instruction_word),
      .dec              (dec)
   );

   rvx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (dec),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   rvx_back #(
      .DATA_WORDS  (DATA_WORDS),
      .INSTR_WORDS (INSTR_WORDS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .q_valid                (q_valid),
      .q_data                 (q_data),
      .q_pop                  (q_pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_next_fetch_address (rsp_next_fetch_address),
      .rsp_write_enable       (rsp_write_enable),
      .rsp_write_index        (rsp_write_index),
      .rsp_write_value        (rsp_write_value),
      .rsp_halt_status        (rsp_halt_status)
   );

endmodule

[rtl/core/rvx_front.sv]
// rvx_front: decodes one instruction word into an op class, register indexes and immediate
// depends on rvx_pkg
module rvx_front
   import rvx_pkg::*;
(
   input  logic [IWORD_W-1:0] instruction_word,
   output dec_type            dec
);

   logic [IWORD_W-1:0]  w;
   logic [IMM_W-1:0]    imm_i;
   logic [IMM_W-1:0]    imm_s;
   logic [IMM_W-1:0]    imm_b;
   logic [IMM_W-1:0]    imm_j;

   assign w = instruction_word;

   // all immediates sign-extended to the widest (jal) format
   assign imm_i = {{9{w[31]}}, w[31:20]};
   assign imm_s = {{9{w[31]}}, w[31:25], w[11:7]};
   assign imm_b = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign imm_j = {w[31], w[19:12], w[20], w[30:21], 1'b0};

   always_comb begin
      dec.is_zero = (w == '0);
      dec.rd      = w[11:7];
      dec.rs1     = w[19:15];
      dec.rs2     = w[24:20];
      dec.op      = OPC_NONE;
      dec.imm     = imm_i;
      case (w[6:0])
         OPCODE_ADD:  dec.op = OPC_ADD;
         OPCODE_ADDI: dec.op = OPC_ADDI;
         OPCODE_JAL: begin
            dec.op  = OPC_JAL;
            dec.imm = imm_j;
         end
         OPCODE_JALR: dec.op = OPC_JALR;
         OPCODE_BEQ: begin
            dec.op  = OPC_BEQ;
            dec.imm = imm_b;
         end
         OPCODE_LD:   dec.op = OPC_LD;
         OPCODE_SD: begin
            dec.op  = OPC_SD;
            dec.imm = imm_s;
         end
         default:     dec.op = OPC_NONE;
      endcase
   end

endmodule

[rtl/core/rvx_queue.sv]
// rvx_queue: small fifo of decoded instructions between decode and execute
// depends on rvx_pkg
module rvx_queue
   import rvx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  dec_type push_data,
   output logic    pop_valid,
   input  logic    pop,
   output dec_type pop_data
);

   dec_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/rvx_back.sv]
// rvx_back: execute sequencer with register file, data store, pc, halt state and result register
// depends on rvx_pkg
module rvx_back
   import rvx_pkg::*;
#(
   parameter int DATA_WORDS  = DEF_DATA_WORDS,
   parameter int INSTR_WORDS = DEF_INSTR_WORDS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [XLEN-1:0]        csr_wdata,
   input  logic                   q_valid,
   input  dec_type                q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FETCH_W-1:0]     rsp_next_fetch_address,
   output logic                   rsp_write_enable,
   output logic [REG_IDX_W-1:0]   rsp_write_index,
   output logic signed [XLEN-1:0] rsp_write_value,
   output logic [HALT_W-1:0]      rsp_halt_status
);

   localparam int IA = $clog2(INSTR_WORDS);
   localparam int DA = $clog2(DATA_WORDS);

   localparam logic [1:0] ST_READ = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   // three copies of the register file, one per read port
   logic [XLEN-1:0]      rf_a_mem [RF_DEPTH];
   logic [XLEN-1:0]      rf_b_mem [RF_DEPTH];
   logic [XLEN-1:0]      rf_s_mem [RF_DEPTH];
   logic [RF_DEPTH-1:0]  rf_valid_ff, rf_valid_in;
   logic [XLEN-1:0]      dmem [DATA_WORDS];

   logic [1:0]           state_ff, state_in;
   logic [IA-1:0]        pc_ff, pc_in;
   logic [HALT_W-1:0]    halted_ff, halted_in;
   logic [REG_IDX_W-1:0] stop_reg_ff;
   logic [XLEN-1:0]      stop_val_ff;
   dec_type              e_ff;

   logic [XLEN-1:0]      rf_a_rd_ff, rf_b_rd_ff, rf_s_rd_ff;
   logic                 a_ok_ff, b_ok_ff, s_ok_ff;
   logic [XLEN-1:0]      dm_rd_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FETCH_W-1:0]   rsp_fetch_ff;
   logic                 rsp_wen_ff;
   logic [REG_IDX_W-1:0] rsp_widx_ff;
   logic [XLEN-1:0]      rsp_wval_ff;
   logic [HALT_W-1:0]    rsp_halt_ff;

   logic [XLEN-1:0]      a_val, b_val, imm64, opnd, alu, stop_cur, post_stop, link;
   logic [IA+1:0]        br_target;
   logic [IA-1:0]        next_seq;
   logic [DA-1:0]        dm_idx;
   logic                 out_free, exec_run, commit, dm_re, dm_we;
   logic                 c_wen;
   logic [XLEN-1:0]      c_wval;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign exec_run = (halted_ff == HALT_RUN) && !e_ff.is_zero;
   assign q_pop    = (state_ff == ST_READ) && q_valid;

   assign a_val    = a_ok_ff ? rf_a_rd_ff : '0;
   assign b_val    = b_ok_ff ? rf_b_rd_ff : '0;
   assign stop_cur = s_ok_ff ? rf_s_rd_ff : '0;
   assign imm64    = {{(XLEN-IMM_W){e_ff.imm[IMM_W-1]}}, e_ff.imm};
   assign opnd     = (e_ff.op == OPC_ADD) ? b_val : imm64;
   assign alu      = a_val + opnd;
   assign next_seq = pc_ff + 1'b1;
   assign link     = XLEN'({next_seq, 2'b00});
   // only the bits that survive the wrap matter for pc-relative targets
   assign br_target = {pc_ff, 2'b00} + imm64[IA+1:0];
   assign dm_idx    = alu[DA+2:3];

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      commit    = 1'b0;
      dm_re     = 1'b0;
      c_wen     = 1'b0;
      c_wval    = '0;
      post_stop = stop_cur;
      case (state_ff)
         ST_READ: begin
            if (q_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_run && e_ff.op == OPC_LD) begin
               dm_re    = 1'b1;
               state_in = ST_LOAD;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = ST_READ;
            end
         end
         default: state_in = ST_READ;
      endcase

      if (commit && halted_ff == HALT_RUN) begin
         if (e_ff.is_zero) begin
            halted_in = HALT_ZERO;
         end else begin
            pc_in = next_seq;
            case (e_ff.op)
               OPC_ADD, OPC_ADDI: begin
                  c_wen  = 1'b1;
                  c_wval = alu;
               end
               OPC_JAL: begin
                  c_wen  = 1'b1;
                  c_wval = link;
                  pc_in  = br_target[IA+1:2];
               end
               OPC_JALR: begin
                  c_wen  = 1'b1;
                  c_wval = link;
                  pc_in  = alu[IA+1:2];
               end
               OPC_BEQ: begin
                  if (a_val == b_val) begin
                     pc_in = br_target[IA+1:2];
                  end
               end
               OPC_LD: begin
                  c_wen  = 1'b1;
                  c_wval = dm_rd_ff;
               end
               default: c_wen = 1'b0;
            endcase
            if (e_ff.rd == '0) begin
               c_wen  = 1'b0;
               c_wval = '0;
            end
            // stop check sees this instruction's own write
            if (c_wen && e_ff.rd == stop_reg_ff) begin
               post_stop = c_wval;
            end
            if (post_stop == stop_val_ff) begin
               halted_in = HALT_STOP;
            end
         end
      end
   end

   assign dm_we     = commit && (state_ff == ST_EXEC) && exec_run && (e_ff.op == OPC_SD);

   always_comb begin
      rf_valid_in = rf_valid_ff;
      if (c_wen) begin
         rf_valid_in[e_ff.rd] = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READ;
         pc_ff        <= '0;
         halted_ff    <= HALT_RUN;
         rf_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         stop_reg_ff  <= STOP_REG_RST;
         stop_val_ff  <= STOP_VAL_RST;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rf_valid_ff  <= rf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_STOP_REG) begin
            stop_reg_ff <= csr_wdata[REG_IDX_W-1:0];
         end
         if (csr_we && csr_index == CSR_STOP_VAL) begin
            stop_val_ff <= csr_wdata;
         end
      end
   end

   // operand fetch from the register file copies
   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_ff       <= q_data;
         rf_a_rd_ff <= rf_a_mem[q_data.rs1];
         rf_b_rd_ff <= rf_b_mem[q_data.rs2];
         rf_s_rd_ff <= rf_s_mem[stop_reg_ff];
         a_ok_ff    <= (q_data.rs1 != '0) && rf_valid_ff[q_data.rs1];
         b_ok_ff    <= (q_data.rs2 != '0) && rf_valid_ff[q_data.rs2];
         s_ok_ff    <= (stop_reg_ff != '0) && rf_valid_ff[stop_reg_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (c_wen) begin
         rf_a_mem[e_ff.rd] <= c_wval;
         rf_b_mem[e_ff.rd] <= c_wval;
         rf_s_mem[e_ff.rd] <= c_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_idx] <= b_val;
      end
      if (dm_re) begin
         dm_rd_ff <= dmem[dm_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_fetch_ff <= FETCH_W'({pc_in, 2'b00});
         rsp_wen_ff   <= c_wen;
         rsp_widx_ff  <= c_wen ? e_ff.rd : '0;
         rsp_wval_ff  <= c_wval;
         rsp_halt_ff  <= halted_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_next_fetch_address = rsp_fetch_ff;
   assign rsp_write_enable       = rsp_wen_ff;
   assign rsp_write_index        = rsp_widx_ff;
   assign rsp_write_value        = rsp_wval_ff;
   assign rsp_halt_status        = rsp_halt_ff;

endmodule

[tb/rv64_subset_instruction_executor_checker.sv]
// result checker for the rv64 subset executor: tracks pc, registers, data store and halt
// state from accepted words and compares every result word; depends on rvx_pkg
`timescale 1ns / 1ps
module rv64_subset_instruction_executor_checker
   import rvx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [XLEN-1:0]        csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [IWORD_W-1:0]     req_instruction_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [FETCH_W-1:0]     rsp_next_fetch_address,
   input  logic                   rsp_write_enable,
   input  logic [REG_IDX_W-1:0]   rsp_write_index,
   input  logic signed [XLEN-1:0] rsp_write_value,
   input  logic [HALT_W-1:0]      rsp_halt_status,
   output int                     mismatch_count,
   output int                     in_flight
);

   localparam int PC_W = $clog2(DEF_INSTR_WORDS);

   typedef struct packed {
      logic [FETCH_W-1:0]   fetch;
      logic                 wen;
      logic [REG_IDX_W-1:0] widx;
      logic [XLEN-1:0]      wval;
      logic [HALT_W-1:0]    halt;
   } retire_rec;

   logic [PC_W-1:0]      pc;
   logic [XLEN-1:0]      gpr [RF_DEPTH];
   logic [XLEN-1:0]      dmem [int];
   logic [HALT_W-1:0]    halt;
   logic [REG_IDX_W-1:0] stop_reg;
   logic [XLEN-1:0]      stop_val;
   retire_rec            retire_queue [$];
   int                   errors = 0;
   int                   checked = 0;

   assign mismatch_count = errors;

   function automatic logic [XLEN-1:0] gpr_read(input logic [REG_IDX_W-1:0] idx);
      return (idx == '0) ? '0 : gpr[idx];
   endfunction

   function automatic logic [PC_W-1:0] word_index(input logic [XLEN-1:0] byte_addr);
      return PC_W'((byte_addr >> 2) % DEF_INSTR_WORDS);
   endfunction

   function automatic int data_slot(input logic [XLEN-1:0] byte_addr);
      return int'((byte_addr >> 3) % DEF_DATA_WORDS);
   endfunction

   // executes one word against the tracked state and returns its result word
   function automatic retire_rec retire_word(input logic [IWORD_W-1:0] w);
      retire_rec            r;
      logic [6:0]           opc;
      logic [REG_IDX_W-1:0] rd;
      logic [XLEN-1:0]      a, b, imm_i, imm_s, imm_b, imm_j, pc_bytes, wval;
      logic [PC_W-1:0]      nxt;
      logic                 wen;
      int                   slot;
      wen  = 1'b0;
      wval = '0;
      rd   = '0;
      if (halt == HALT_RUN && w == '0)
         halt = HALT_ZERO;
      if (halt == HALT_RUN) begin
         opc      = w[6:0];
         rd       = w[11:7];
         a        = gpr_read(w[19:15]);
         b        = gpr_read(w[24:20]);
         imm_i    = {{52{w[31]}}, w[31:20]};
         imm_s    = {{52{w[31]}}, w[31:25], w[11:7]};
         imm_b    = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         imm_j    = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         pc_bytes = XLEN'(pc) << 2;
         // wraps with the instruction space
         nxt      = pc + 1'b1;
         case (opc)
            OPCODE_ADD: begin
               wen  = 1'b1;
               wval = a + b;
            end
            OPCODE_ADDI: begin
               wen  = 1'b1;
               wval = a + imm_i;
            end
            OPCODE_JAL: begin
               wen  = 1'b1;
               wval = XLEN'({nxt, 2'b00});
               nxt  = word_index(pc_bytes + imm_j);
            end
            OPCODE_JALR: begin
               wen  = 1'b1;
               wval = XLEN'({nxt, 2'b00});
               nxt  = word_index((a + imm_i) & ~XLEN'(1));
            end
            OPCODE_BEQ: begin
               if (a == b)
                  nxt = word_index(pc_bytes + imm_b);
            end
            OPCODE_LD: begin
               wen  = 1'b1;
               slot = data_slot(a + imm_i);
               wval = dmem.exists(slot) ? dmem[slot] : '0;
            end
            OPCODE_SD: begin
               dmem[data_slot(a + imm_s)] = b;
            end
            default: ;
         endcase
         if (wen && rd != '0) begin
            gpr[rd] = wval;
         end else begin
            wen  = 1'b0;
            wval = '0;
            rd   = '0;
         end
         pc = nxt;
         // stop check sees the registers after this word's write
         if (gpr_read(stop_reg) == stop_val)
            halt = HALT_STOP;
      end
      r.fetch = FETCH_W'({pc, 2'b00});
      r.wen   = wen;
      r.widx  = rd;
      r.wval  = wval;
      r.halt  = halt;
      return r;
   endfunction

   task automatic report_field(input string what, input logic [XLEN-1:0] got,
                               input logic [XLEN-1:0] want);
      if (errors < 40)
         $display("[%0t] result %0d %s: got %0h, want %0h", $time, checked, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      retire_rec want;
      if (reset) begin
         pc = '0;
         for (int i = 0; i < RF_DEPTH; i++)
            gpr[i] = '0;
         dmem.delete();
         halt     = HALT_RUN;
         stop_reg = STOP_REG_RST;
         stop_val = STOP_VAL_RST;
         retire_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STOP_REG: stop_reg = csr_wdata[REG_IDX_W-1:0];
               CSR_STOP_VAL: stop_val = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            retire_queue.push_back(retire_word(req_instruction_word));
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (retire_queue.size() == 0) begin
               report_field("result word with nothing pending",
                            XLEN'(rsp_next_fetch_address), '0);
            end else begin
               want = retire_queue.pop_front();
               if (rsp_next_fetch_address !== want.fetch)
                  report_field("next_fetch_address", XLEN'(rsp_next_fetch_address),
                               XLEN'(want.fetch));
               if (rsp_write_enable !== want.wen)
                  report_field("write_enable", XLEN'(rsp_write_enable), XLEN'(want.wen));
               if (rsp_write_index !== want.widx)
                  report_field("write_index", XLEN'(rsp_write_index), XLEN'(want.widx));
               if (rsp_write_value !== want.wval)
                  report_field("write_value", rsp_write_value, want.wval);
               if (rsp_halt_status !== want.halt)
                  report_field("halt_status", XLEN'(rsp_halt_status), XLEN'(want.halt));
            end
         end
      end
      in_flight <= retire_queue.size();
   end

endmodule

[tb/rv64_subset_instruction_executor_tb.sv]
// testbench top for the rv64 subset executor: clock, reset, instruction stimulus, stop
// settings and verdict; depends on rvx_pkg, the executor rtl and the result checker
`timescale 1ns / 1ps
module rv64_subset_instruction_executor_tb;
   import rvx_pkg::*;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int RANDOM_WORDS = 800;
   localparam int PHASES       = 6;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [XLEN-1:0]        csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [IWORD_W-1:0]     req_instruction_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [FETCH_W-1:0]     rsp_next_fetch_address;
   logic                   rsp_write_enable;
   logic [REG_IDX_W-1:0]   rsp_write_index;
   logic signed [XLEN-1:0] rsp_write_value;
   logic [HALT_W-1:0]      rsp_halt_status;

   int          mismatch_count;
   int          in_flight;
   int          cycle_count = 0;
   int          send_idle_pct = 20;
   int          recv_idle_pct = 77;
   int          words_sent = 0;
   int          loads_sent = 0;
   int          stores_sent = 0;
   int          settings_used = 0;
   logic [HALT_W-1:0] last_halt = HALT_RUN;
   bit          written_map [DEF_DATA_WORDS];

   always #2 clock = ~clock;

   rv64_subset_instruction_executor DUT (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_instruction_word   (req_instruction_word),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_next_fetch_address (rsp_next_fetch_address),
      .rsp_write_enable       (rsp_write_enable),
      .rsp_write_index        (rsp_write_index),
      .rsp_write_value        (rsp_write_value),
      .rsp_halt_status        (rsp_halt_status)
   );

   rv64_subset_instruction_executor_checker u_check (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_instruction_word   (req_instruction_word),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_next_fetch_address (rsp_next_fetch_address),
      .rsp_write_enable       (rsp_write_enable),
      .rsp_write_index        (rsp_write_index),
      .rsp_write_value        (rsp_write_value),
      .rsp_halt_status        (rsp_halt_status),
      .mismatch_count         (mismatch_count),
      .in_flight              (in_flight)
   );

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_valid && rsp_ready)
         last_halt <= rsp_halt_status;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rv64_subset_instruction_executor: mismatch");
         $finish;
      end
   end

   // instruction encoders; funct3 and funct7 are filled at random
   function automatic logic [31:0] enc_r(input logic [4:0] rd, rs1, rs2);
      return {7'($urandom), rs2, rs1, 3'($urandom), rd, OPCODE_ADD};
   endfunction

   function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd, rs1,
                                         input logic [11:0] imm);
      return {imm, rs1, 3'($urandom), rd, op};
   endfunction

   function automatic logic [31:0] enc_s(input logic [4:0] rs1, rs2, input logic [11:0] imm);
      return {imm[11:5], rs2, rs1, 3'($urandom), imm[4:0], OPCODE_SD};
   endfunction

   function automatic logic [31:0] enc_b(input logic [4:0] rs1, rs2, input logic [12:0] imm);
      return {imm[12], imm[10:5], rs2, rs1, 3'($urandom), imm[4:1], imm[11], OPCODE_BEQ};
   endfunction

   function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPCODE_JAL};
   endfunction

   function automatic int data_slot(input logic [XLEN-1:0] base_val, input logic [11:0] off);
      logic [XLEN-1:0] sum;
      sum = base_val + {{52{off[11]}}, off};
      return int'((sum >> 3) % DEF_DATA_WORDS);
   endfunction

   task automatic send_word(input logic [IWORD_W-1:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_instruction_word <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
   endtask

   // stop sending until every result word is back
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (in_flight != 0);
   endtask

   task automatic configure(input logic [REG_IDX_W-1:0] reg_idx, input logic [XLEN-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_STOP_REG;
      csr_wdata <= {$urandom, 27'($urandom), reg_idx};
      @(posedge clock);
      csr_index <= CSR_STOP_VAL;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic store_x0(input logic [4:0] rs2, input logic [11:0] off);
      written_map[data_slot('0, off)] = 1'b1;
      send_word(enc_s(5'd0, rs2, off));
      stores_sent++;
   endtask

   task automatic load_word(input logic [4:0] rd, rs1, input logic [11:0] off);
      send_word(enc_i(OPCODE_LD, rd, rs1, off));
      loads_sent++;
   endtask

   // build a base address in a register, store through it, then load back
   task automatic mem_sequence();
      logic [REG_IDX_W-1:0] base, dest;
      logic [XLEN-1:0]      base_val;
      logic [11:0]          imm, off;
      logic [11:0]          offs [$];
      int                   pairs;
      base     = '0;
      base_val = '0;
      if ($urandom_range(3) != 0) begin
         base = 5'($urandom_range(1, 31));
         imm  = 12'($urandom);
         send_word(enc_i(OPCODE_ADDI, base, 5'd0, imm));
         base_val = {{52{imm[11]}}, imm};
         repeat ($urandom_range(0, 10)) begin
            send_word(enc_r(base, base, base));
            base_val = base_val << 1;
         end
      end
      pairs = $urandom_range(1, 3);
      repeat (pairs) begin
         off = 12'($urandom);
         written_map[data_slot(base_val, off)] = 1'b1;
         send_word(enc_s(base, 5'($urandom), off));
         stores_sent++;
         offs.push_back(off);
      end
      repeat (pairs) begin
         do
            dest = 5'($urandom);
         while (dest == base && base != '0);
         load_word(dest, base, offs[$urandom_range(0, offs.size() - 1)]);
      end
      // an offset of its own, loaded only if something is known to sit there
      off = 12'($urandom);
      if (written_map[data_slot(base_val, off)])
         load_word(5'($urandom), base, off);
   endtask

   task automatic single_word();
      logic [4:0] rd, rs1;
      rd  = 5'($urandom);
      rs1 = 5'($urandom);
      case ($urandom_range(5))
         0: send_word(enc_r(rd, rs1, 5'($urandom)));
         1: send_word(enc_i(OPCODE_ADDI, rd, rs1, 12'($urandom)));
         2: send_word(enc_j(rd, 21'($urandom)));
         3: send_word(enc_i(OPCODE_JALR, rd, rs1, 12'($urandom)));
         4: send_word(enc_b(rs1, $urandom_range(1) ? rs1 : 5'($urandom), 13'($urandom)));
         default: begin
            send_word(enc_s(rs1, 5'($urandom), 12'($urandom)));
            stores_sent++;
         end
      endcase
   endtask

   // any nonzero word except a load, whose address could not be known here
   function automatic logic [31:0] noise_word();
      logic [31:0] w;
      w = $urandom;
      if (w == '0)
         w = 32'h1;
      if (w[6:0] == OPCODE_LD)
         w[5] = 1'b1;
      return w;
   endfunction

   initial begin : stimulus
      logic [XLEN-1:0]      big;
      logic [REG_IDX_W-1:0] r;
      int                   target, pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stop on x0 against a nonzero value never fires
      configure(5'd0, 64'h7fff_ffff_ffff_ffff);
      send_word(enc_i(OPCODE_ADDI, 5'd1, 5'd0, 12'h7ff));
      send_word(enc_i(OPCODE_ADDI, 5'd2, 5'd0, 12'h800));
      send_word(enc_r(5'd3, 5'd1, 5'd2));
      send_word(enc_r(5'd0, 5'd1, 5'd2));
      send_word(enc_i(OPCODE_ADDI, 5'd31, 5'd31, 12'hfff));
      store_x0(5'd1, 12'h000);
      store_x0(5'd3, 12'hff8);
      store_x0(5'd2, 12'h7ff);
      load_word(5'd4, 5'd0, 12'h000);
      load_word(5'd5, 5'd0, 12'hff8);
      load_word(5'd31, 5'd0, 12'h7ff);
      load_word(5'd0, 5'd0, 12'h000);
      // jump targets that wrap both ways, and link into x0
      send_word(enc_j(5'd6, 21'h0ffffe));
      send_word(enc_j(5'd7, 21'h100000));
      send_word(enc_j(5'd0, 21'h000000));
      send_word(enc_i(OPCODE_JALR, 5'd8, 5'd3, 12'h000));
      send_word(enc_i(OPCODE_JALR, 5'd9, 5'd1, 12'h800));
      send_word(enc_b(5'd1, 5'd1, 13'h0ffe));
      send_word(enc_b(5'd1, 5'd2, 13'h1000));
      send_word(enc_b(5'd0, 5'd0, 13'h1000));
      send_word(32'h1234_5037);
      send_word(32'hffff_ffff);
      send_word(32'h8000_0000);

      for (int p = 0; p < PHASES; p++) begin
         case (p / 2)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 77;
            end
            1: begin
               send_idle_pct = 77;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // large stop values stay out of reach of the values the words produce
         big     = {$urandom, $urandom};
         big[62] = ~big[63];
         case (p)
            0: configure(5'd0, 64'h7fff_ffff_ffff_ffff);
            1: configure(5'd31, 64'h8000_0000_0000_0000);
            2: configure(5'($urandom_range(1, 30)), big);
            3: configure(5'd31, 64'h7fff_ffff_ffff_ffff);
            4: configure(5'd0, 64'h8000_0000_0000_0000);
            default: configure(5'($urandom_range(1, 30)), big);
         endcase
         target = words_sent + RANDOM_WORDS / PHASES;
         while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 2)
               drain();
            else if (pick < 55)
               mem_sequence();
            else if (pick < 90)
               single_word();
            else
               send_word(noise_word());
         end
      end

      // halting is sticky, so one of the two halt causes closes the run
      if ($urandom_range(1)) begin
         r = 5'($urandom_range(1, 31));
         big = 64'($urandom_range(1, 2047));
         configure(r, big);
         send_word(enc_i(OPCODE_ADDI, r, 5'd0, big[11:0]));
      end else begin
         send_word('0);
      end
      // words after the halt are ignored
      repeat (6) send_word(noise_word());
      send_word('0);
      send_word(enc_i(OPCODE_ADDI, 5'd1, 5'd1, 12'h001));

      drain();
      repeat (10) @(posedge clock);
      $display("ran %0d words (%0d stores, %0d loads) under %0d stop settings", words_sent,
               stores_sent, loads_sent, settings_used);
      $display("three idle mixes, ending in halt status %0d", last_halt);
      if (mismatch_count == 0)
         $display("rv64_subset_instruction_executor: match");
      else
         $display("rv64_subset_instruction_executor: mismatch");
      $finish;
   end

endmodule

[sim.f]
rtl/core/rvx_pkg.sv
rtl/core/rvx_front.sv
rtl/core/rvx_queue.sv
rtl/core/rvx_back.sv
rtl/core/rv64_subset_instruction_executor.sv
tb/rv64_subset_instruction_executor_checker.sv
tb/rv64_subset_instruction_executor_tb.sv
